// ===== hdl/hs1_pkg.sv =====
//------------------------------------------------------------------------------
// hs1_pkg: shared types and constants for the HMAC-SHA1 stream block.
// Holds the payload structs, sequencer states and SHA-1 constants.
//------------------------------------------------------------------------------
package hs1_pkg;

	localparam int BlockBytes = 64;
	localparam int BlockWords = BlockBytes / 4;
	localparam int CfgRegs = BlockBytes / 8;
	localparam int CfgIdxW = $clog2(CfgRegs);
	localparam logic [7:0] IpadByte = 8'h36;
	localparam logic [7:0] OpadByte = 8'h5C;
	localparam logic [31:0] OuterLenBits = 32'((BlockBytes + 20) * 8);

	typedef struct packed {
		logic [7:0] msg_byte;
		logic       byte_present;
		logic       msg_end;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        digest_last;
	} out_item_t;

	typedef logic [4:0][31:0] chain_t;

	localparam chain_t ShaIv = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEYI,
		ST_BYTE,
		ST_PAD80,
		ST_PADZ,
		ST_PADLEN,
		ST_KEYO,
		ST_OUTER,
		ST_EMIT,
		ST_WAIT
	} state_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		rotl = (x << n) | (x >> (32 - n));
	endfunction

endpackage

// ===== hdl/hs1_core.sv =====
//------------------------------------------------------------------------------
// hs1_core: SHA-1 compression unit.
// Runs one round per cycle with a 16-word rolling schedule,
// then adds the working variables into the chain.
//------------------------------------------------------------------------------
module hs1_core
	import hs1_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  chain_t                      chain_in,
	input  logic [BlockWords-1:0][31:0] blk,
	output logic                        busy,
	output logic                        done,
	output chain_t                      chain_out
);

	logic [BlockWords-1:0][31:0] w_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [6:0]  rnd_q;
	logic        busy_q, done_q;
	chain_t      base_q, res_q;
	logic [31:0] f, k, tmp, wnext;

	always_comb begin
		if (rnd_q < 7'd20) begin
			f = (b_q & c_q) | (~b_q & d_q);
			k = 32'h5A827999;
		end else if (rnd_q < 7'd40) begin
			f = b_q ^ c_q ^ d_q;
			k = 32'h6ED9EBA1;
		end else if (rnd_q < 7'd60) begin
			f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k = 32'h8F1BBCDC;
		end else begin
			f = b_q ^ c_q ^ d_q;
			k = 32'hCA62C1D6;
		end
		tmp = rotl(a_q, 5) + f + e_q + k + w_q[0];
		wnext = rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q <= '0;
			end else if (busy_q) begin
				if (rnd_q == 7'd79) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				rnd_q <= rnd_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			w_q <= blk;
			base_q <= chain_in;
			{e_q, d_q, c_q, b_q, a_q} <= chain_in;
		end else if (busy_q) begin
			w_q <= {wnext, w_q[BlockWords-1:1]};
			e_q <= d_q;
			d_q <= c_q;
			c_q <= rotl(b_q, 30);
			b_q <= a_q;
			a_q <= tmp;
			if (rnd_q == 7'd79) begin
				res_q[0] <= base_q[0] + tmp;
				res_q[1] <= base_q[1] + a_q;
				res_q[2] <= base_q[2] + rotl(b_q, 30);
				res_q[3] <= base_q[3] + c_q;
				res_q[4] <= base_q[4] + d_q;
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign chain_out = res_q;

endmodule

// ===== hdl/hmac_sha1_stream.sv =====
//------------------------------------------------------------------------------
// hmac_sha1_stream: HMAC-SHA1 over a byte stream.
// Input items carry one optional byte and an end mark; results are five words.
//------------------------------------------------------------------------------
// The key block must be written through the cfg channel (eight 64-bit registers,
// first byte in the top bits) while the block is idle; the block does not check it.
// The first item of a message hashes the key XOR 0x36.
// A byte item that completes a block waits for that block's compression.
// An end item pads and finishes the inner hash (one or two compressions),
// then runs the two outer compressions, each compression being 80 rounds
// of the single shared round unit.
// The five digest words then leave on the out channel, first word first,
// one per cycle while out_stall is low; out_stall holds the current word.
// in_stall is high whenever an item is in work or results are pending.
// Reset clears the key and all control and loads the SHA-1 IV into the chain state.
//------------------------------------------------------------------------------
module hmac_sha1_stream
	import hs1_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW:0]   cfg_index,
	input  logic [63:0]        cfg_value
);

	state_t state_q, state_d;
	logic [CfgRegs-1:0][63:0] key_q;
	chain_t chain_q, inner_q;
	logic [BlockWords-1:0][31:0] buf_q, cblk;
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic        kdone_q, end_q;
	logic [2:0]  len_cnt_q, emit_q;
	in_item_t    item_q;
	logic        cmp_start, cmp_busy, cmp_done;
	chain_t      cmp_out;
	logic        acc, put, full;
	logic [7:0]  pbyte;

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);
	assign acc = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) key_q <= '0;
		else if (cfg_valid && cfg_index < (CfgIdxW+1)'(CfgRegs))
			key_q[cfg_index[CfgIdxW-1:0]] <= cfg_value;
	end

	function automatic logic [BlockWords-1:0][31:0] kblk(input logic [7:0] p);
		logic [BlockWords-1:0][31:0] r;
		for (int j = 0; j < BlockWords; j++)
			r[j] = (j % 2 == 1 ? key_q[j/2][31:0] : key_q[j/2][63:32]) ^ {4{p}};
		return r;
	endfunction

	// The byte placed this cycle is merged in, so a block that fills now is hashed whole.
	always_comb begin
		cblk = buf_q;
		if (put) cblk[fill_q[5:2]][8*(3 - fill_q[1:0]) +: 8] = pbyte;
		if (state_q == ST_KEYI) cblk = kblk(IpadByte);
		else if (state_q == ST_KEYO) cblk = kblk(OpadByte);
		else if (state_q == ST_OUTER) begin
			cblk = '0;
			for (int j = 0; j < 5; j++) cblk[j] = inner_q[j];
			cblk[5] = 32'h80000000;
			cblk[BlockWords-1] = OuterLenBits;
		end
	end

	// Byte being placed into the block buffer this cycle.
	always_comb begin
		put = 1'b0;
		pbyte = 8'h00;
		case (state_q)
			ST_BYTE: begin
				put = item_q.byte_present;
				pbyte = item_q.msg_byte;
			end
			ST_PAD80: begin
				put = 1'b1;
				pbyte = 8'h80;
			end
			ST_PADZ: put = (fill_q != 6'd56);
			ST_PADLEN: begin
				put = 1'b1;
				pbyte = len_q[63 - 8*len_cnt_q -: 8];
			end
			default: put = 1'b0;
		endcase
		full = put && (fill_q == 6'd63);
	end

	assign cmp_start = (!cmp_busy && !cmp_done) && (full || state_q == ST_KEYI
		|| state_q == ST_KEYO || state_q == ST_OUTER);

	hs1_core u_core (
		.clk(clk), .arst_n(arst_n), .start(cmp_start), .chain_in(chain_q),
		.blk(cblk), .busy(cmp_busy), .done(cmp_done), .chain_out(cmp_out)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc) state_d = kdone_q ? ST_BYTE : ST_KEYI;
			ST_KEYI: if (cmp_done) state_d = ST_BYTE;
			ST_BYTE: if (!(full || cmp_busy)) state_d = end_q ? ST_PAD80 : ST_IDLE;
			ST_PAD80: if (!(full || cmp_busy)) state_d = ST_PADZ;
			ST_PADZ: if (!(full || cmp_busy) && fill_q == 6'd56) state_d = ST_PADLEN;
			ST_PADLEN: if (cmp_done) state_d = ST_KEYO;
			ST_KEYO: if (cmp_done) state_d = ST_OUTER;
			ST_OUTER: if (cmp_done) state_d = ST_EMIT;
			ST_EMIT: if (!out_stall && emit_q == 3'd4) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			chain_q <= ShaIv;
			inner_q <= '0;
			len_q <= '0;
			fill_q <= '0;
			kdone_q <= 1'b0;
			end_q <= 1'b0;
			len_cnt_q <= '0;
			emit_q <= '0;
		end else begin
			state_q <= state_d;
			if (acc) begin
				end_q <= in_data.msg_end;
				if (in_data.byte_present) len_q <= len_q + 64'd8;
			end
			if (state_q == ST_IDLE && acc && !kdone_q) begin
				chain_q <= ShaIv;
				len_q <= 64'(BlockBytes * 8) + (in_data.byte_present ? 64'd8 : 64'd0);
				fill_q <= '0;
				kdone_q <= 1'b1;
			end
			if (cmp_done) chain_q <= cmp_out;
			if (put && !cmp_busy && !cmp_done) begin
				fill_q <= fill_q + 6'd1;
				if (state_q == ST_PADLEN) len_cnt_q <= len_cnt_q + 3'd1;
			end
			if (state_q == ST_PADLEN && cmp_done) begin
				inner_q <= cmp_out;
				chain_q <= ShaIv;
				len_cnt_q <= '0;
			end
			if (state_q == ST_EMIT && !out_stall) begin
				emit_q <= emit_q + 3'd1;
				if (emit_q == 3'd4) begin
					emit_q <= '0;
					chain_q <= ShaIv;
					len_q <= '0;
					fill_q <= '0;
					kdone_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) item_q <= in_data;
		if (put && !cmp_busy && !cmp_done)
			buf_q[fill_q[5:2]][8*(3 - fill_q[1:0]) +: 8] <= pbyte;
	end

	assign out_valid = (state_q == ST_EMIT);
	assign out_data.digest_word = chain_q[emit_q];
	assign out_data.digest_last = (emit_q == 3'd4);

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input open during emit");
	a_fill_word: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PADLEN && !cmp_busy && !cmp_done) |-> fill_q[5:3] == 3'd7)
		else $error("length not at block tail");
	a_one_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_done |-> !cmp_busy) else $error("compression overlap");
	a_emit_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> emit_q <= 3'd4) else $error("emit index out of range");

endmodule
